[design/iihc_pkg.sv]
// Shared types and constants for the ignition interlock and headlight controller.
package iihc_pkg;

    localparam int AVG_DEPTH   = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int LEVEL_W     = 16;
    localparam int MASK_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int RING_IDX_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W       = $clog2(AVG_DEPTH * ((1 << LEVEL_W) - 1) + 1);

    localparam logic [LEVEL_W-1:0] SAMPLE_KEEP =
        LEVEL_W'({LEVEL_W{1'b1}} << (LEVEL_W - SAMPLE_BITS));

    localparam logic [LEVEL_W-1:0] LIGHT_ON_RESET  = 16'd39322;
    localparam logic [LEVEL_W-1:0] MODE_ON_RESET   = 16'd21627;
    localparam logic [LEVEL_W-1:0] MODE_AUTO_RESET = 16'd43253;

    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_ON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_ON   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_AUTO = 2'd2;

    typedef struct packed {
        logic [LEVEL_W-1:0] light_on_level;
        logic [LEVEL_W-1:0] mode_on_level;
        logic [LEVEL_W-1:0] mode_auto_level;
    } cfg_t;

    typedef struct packed {
        logic               driver_seat;
        logic               passenger_seat;
        logic               driver_belt;
        logic               passenger_belt;
        logic               ignition_button;
        logic [LEVEL_W-1:0] mode_pot;
        logic [LEVEL_W-1:0] light_sample;
    } in_item_t;

    typedef struct packed {
        logic              ignition_ready;
        logic              engine_running;
        logic              headlight_on;
        logic              buzzer_on;
        logic              msg_welcome;
        logic              msg_started;
        logic              msg_stopped;
        logic              msg_inhibited;
        logic [MASK_W-1:0] missing_mask;
    } out_item_t;

    typedef struct packed {
        logic               update;
        logic [LEVEL_W-1:0] sample;
    } avg_req_t;

endpackage

[design/iihc_ifs.sv]
// Channel interfaces: poll input, result output and configuration write.
interface iihc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        driver_seat;
    logic                        passenger_seat;
    logic                        driver_belt;
    logic                        passenger_belt;
    logic                        ignition_button;
    logic [iihc_pkg::LEVEL_W-1:0] mode_pot;
    logic [iihc_pkg::LEVEL_W-1:0] light_sample;

    modport source (
        output valid, driver_seat, passenger_seat, driver_belt, passenger_belt,
               ignition_button, mode_pot, light_sample,
        input  ready
    );
    modport sink (
        input  valid, driver_seat, passenger_seat, driver_belt, passenger_belt,
               ignition_button, mode_pot, light_sample,
        output ready
    );
endinterface

interface iihc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        ignition_ready;
    logic                        engine_running;
    logic                        headlight_on;
    logic                        buzzer_on;
    logic                        msg_welcome;
    logic                        msg_started;
    logic                        msg_stopped;
    logic                        msg_inhibited;
    logic [iihc_pkg::MASK_W-1:0] missing_mask;

    modport source (
        output valid, ignition_ready, engine_running, headlight_on, buzzer_on,
               msg_welcome, msg_started, msg_stopped, msg_inhibited, missing_mask,
        input  ready
    );
    modport sink (
        input  valid, ignition_ready, engine_running, headlight_on, buzzer_on,
               msg_welcome, msg_started, msg_stopped, msg_inhibited, missing_mask,
        output ready
    );
endinterface

interface iihc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [iihc_pkg::CFG_IDX_W-1:0] index;
    logic [iihc_pkg::LEVEL_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/ignition_interlock_headlight_ctrl_top.sv]
// Top level of the ignition interlock and headlight controller.
// An accepted item waits in the input register; its result loads the result register when that is free or being read.
// Throughput: one item per cycle while the output is not stalled; control state updates once per item as it advances.
// An input item is taken while a finished result waits, until both registers hold.
// Reset clears the engine, latches, light ring and sum, and loads default levels.
module ignition_interlock_headlight_ctrl_top (
    input  logic       clk,
    input  logic       rst_n,
    iihc_in_if.sink    in_ch,
    iihc_out_if.source out_ch,
    iihc_cfg_if.sink   cfg
);

    logic                in_valid_reg;
    logic                in_valid_next;
    iihc_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    iihc_pkg::out_item_t out_item_reg;
    iihc_pkg::cfg_t      levels;
    iihc_pkg::avg_req_t  avg_req;
    iihc_pkg::out_item_t result;
    logic                light_low;
    logic                advance;

    assign advance     = in_valid_reg & (~out_valid_reg | out_ch.ready);
    assign in_ch.ready = ~in_valid_reg | advance;

    assign in_valid_next  = in_ch.ready ? in_ch.valid : in_valid_reg;
    assign out_valid_next = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    iihc_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .levels (levels)
    );

    iihc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .levels    (levels),
        .light_low (light_low),
        .avg_req   (avg_req),
        .result    (result)
    );

    iihc_light_avg u_avg (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (avg_req),
        .light_on_level (levels.light_on_level),
        .light_low      (light_low)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg.driver_seat     <= in_ch.driver_seat;
            in_item_reg.passenger_seat  <= in_ch.passenger_seat;
            in_item_reg.driver_belt     <= in_ch.driver_belt;
            in_item_reg.passenger_belt  <= in_ch.passenger_belt;
            in_item_reg.ignition_button <= in_ch.ignition_button;
            in_item_reg.mode_pot        <= in_ch.mode_pot;
            in_item_reg.light_sample    <= in_ch.light_sample;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.ignition_ready = out_item_reg.ignition_ready;
    assign out_ch.engine_running = out_item_reg.engine_running;
    assign out_ch.headlight_on   = out_item_reg.headlight_on;
    assign out_ch.buzzer_on      = out_item_reg.buzzer_on;
    assign out_ch.msg_welcome    = out_item_reg.msg_welcome;
    assign out_ch.msg_started    = out_item_reg.msg_started;
    assign out_ch.msg_stopped    = out_item_reg.msg_stopped;
    assign out_ch.msg_inhibited  = out_item_reg.msg_inhibited;
    assign out_ch.missing_mask   = out_item_reg.missing_mask;

endmodule

[design/iihc_cfg_regs.sv]
// Configuration register file for the threshold levels.
module iihc_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    iihc_cfg_if.sink       cfg,
    output iihc_pkg::cfg_t levels
);

    iihc_pkg::cfg_t levels_reg;
    iihc_pkg::cfg_t levels_next;

    assign cfg.ready = 1'b1;
    assign levels    = levels_reg;

    always_comb
    begin
        levels_next = levels_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                iihc_pkg::CFG_LIGHT_ON:  levels_next.light_on_level  = cfg.data;
                iihc_pkg::CFG_MODE_ON:   levels_next.mode_on_level   = cfg.data;
                iihc_pkg::CFG_MODE_AUTO: levels_next.mode_auto_level = cfg.data;
                default:                 levels_next = levels_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg.light_on_level  <= iihc_pkg::LIGHT_ON_RESET;
            levels_reg.mode_on_level   <= iihc_pkg::MODE_ON_RESET;
            levels_reg.mode_auto_level <= iihc_pkg::MODE_AUTO_RESET;
        end
        else
        begin
            levels_reg <= levels_next;
        end
    end

endmodule

[design/iihc_light_avg.sv]
// Light sample ring with running sum and average threshold compare.
module iihc_light_avg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  iihc_pkg::avg_req_t           req,
    input  logic [iihc_pkg::LEVEL_W-1:0] light_on_level,
    output logic                         light_low
);

    logic [iihc_pkg::LEVEL_W-1:0]    ring_reg [iihc_pkg::AVG_DEPTH];
    logic [iihc_pkg::RING_IDX_W-1:0] pos_reg;
    logic [iihc_pkg::RING_IDX_W-1:0] pos_next;
    logic [iihc_pkg::SUM_W-1:0]      sum_reg;
    logic [iihc_pkg::SUM_W-1:0]      sum_next;
    logic [iihc_pkg::LEVEL_W-1:0]    sample_q;
    logic [iihc_pkg::SUM_W-1:0]      limit;

    assign sample_q = req.sample & iihc_pkg::SAMPLE_KEEP;
    assign sum_next = sum_reg - iihc_pkg::SUM_W'(ring_reg[pos_reg])
                    + iihc_pkg::SUM_W'(sample_q);
    assign pos_next = (pos_reg == iihc_pkg::RING_IDX_W'(iihc_pkg::AVG_DEPTH - 1))
                    ? '0 : pos_reg + 1'b1;
    assign limit    = iihc_pkg::SUM_W'(light_on_level)
                    * iihc_pkg::SUM_W'(iihc_pkg::AVG_DEPTH);
    assign light_low = (sum_next <= limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < iihc_pkg::AVG_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else if (req.update)
        begin
            ring_reg[pos_reg] <= sample_q;
            pos_reg           <= pos_next;
            sum_reg           <= sum_next;
        end
    end

endmodule

[design/iihc_ctrl.sv]
// Interlock state, engine toggle, alarm latches and headlight mode select.
module iihc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  iihc_pkg::in_item_t    item,
    input  iihc_pkg::cfg_t        levels,
    input  logic                  light_low,
    output iihc_pkg::avg_req_t    avg_req,
    output iihc_pkg::out_item_t   result
);

    logic engine_on_reg, engine_on_next;
    logic welcomed_reg, welcomed_next;
    logic alarm_reg, alarm_next;
    logic report_reg, report_next;
    logic held_reg, held_next;
    logic buzzer_reg, buzzer_next;
    logic all_ok;
    logic indicator;
    logic m_wel, m_start, m_stop, m_inh;
    logic below_on, below_auto, head;

    always_comb
    begin
        engine_on_next = engine_on_reg;
        welcomed_next  = welcomed_reg;
        alarm_next     = alarm_reg;
        report_next    = report_reg;
        held_next      = held_reg;
        buzzer_next    = buzzer_reg;
        m_wel          = 1'b0;
        m_start        = 1'b0;
        m_stop         = 1'b0;
        m_inh          = 1'b0;

        all_ok = item.driver_seat & item.passenger_seat & item.driver_belt
               & item.passenger_belt & ~engine_on_reg;
        indicator = all_ok;

        if (item.driver_seat && !welcomed_reg)
        begin
            welcomed_next = 1'b1;
            m_wel         = 1'b1;
        end

        if (!all_ok && !engine_on_reg && item.ignition_button && !alarm_reg)
        begin
            buzzer_next = 1'b1;
            alarm_next  = 1'b1;
        end

        if (item.ignition_button)
        begin
            held_next = 1'b1;
        end
        else if (held_reg)
        begin
            // act on release
            held_next = 1'b0;
            if (!engine_on_reg && all_ok)
            begin
                engine_on_next = 1'b1;
                indicator      = 1'b0;
                m_start        = 1'b1;
                buzzer_next    = 1'b0;
            end
            else if (engine_on_reg)
            begin
                engine_on_next = 1'b0;
                indicator      = 1'b0;
                m_stop         = 1'b1;
            end
        end

        if (alarm_next && item.ignition_button && !report_reg)
        begin
            alarm_next  = 1'b0;
            m_inh       = 1'b1;
            report_next = 1'b1;
        end
    end

    assign below_on   = (item.mode_pot < levels.mode_on_level);
    assign below_auto = (item.mode_pot < levels.mode_auto_level);

    assign avg_req.update = step & engine_on_next & ~below_on & ~below_auto;
    assign avg_req.sample = item.light_sample;

    assign head = engine_on_next & ~below_on & (below_auto | light_low);

    assign result.ignition_ready = indicator;
    assign result.engine_running = engine_on_next;
    assign result.headlight_on   = head;
    assign result.buzzer_on      = buzzer_next;
    assign result.msg_welcome    = m_wel;
    assign result.msg_started    = m_start;
    assign result.msg_stopped    = m_stop;
    assign result.msg_inhibited  = m_inh;
    assign result.missing_mask   = {~item.passenger_belt, ~item.driver_belt,
                                    ~item.passenger_seat, ~item.driver_seat};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            engine_on_reg <= 1'b0;
            welcomed_reg  <= 1'b0;
            alarm_reg     <= 1'b0;
            report_reg    <= 1'b0;
            held_reg      <= 1'b0;
            buzzer_reg    <= 1'b0;
        end
        else if (step)
        begin
            engine_on_reg <= engine_on_next;
            welcomed_reg  <= welcomed_next;
            alarm_reg     <= alarm_next;
            report_reg    <= report_next;
            held_reg      <= held_next;
            buzzer_reg    <= buzzer_next;
        end
    end

endmodule

[tb/sv/tb_ignition_interlock_headlight_ctrl_top.sv]
// Testbench for the ignition interlock and headlight controller: predicted polls, random traffic.
`timescale 1ns / 100ps

module tb_ignition_interlock_headlight_ctrl_top;

    localparam int LATENCY     = 2;
    localparam int DRAIN_TAIL  = LATENCY + 4;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    logic clk = 1'b0;
    logic rst_n;

    iihc_in_if  in_ch ();
    iihc_out_if out_ch ();
    iihc_cfg_if cfg ();

    ignition_interlock_headlight_ctrl_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    always #2 clk = ~clk;

    // Controller copy: levels and state
    iihc_pkg::cfg_t               levels;
    logic                         engine_on;
    logic                         welcomed;
    logic                         alarm_latched;
    logic                         report_done;
    logic                         button_held;
    logic                         buzzer_drive;
    logic [iihc_pkg::LEVEL_W-1:0] light_ring [iihc_pkg::AVG_DEPTH];
    int unsigned                  ring_pos;
    int unsigned                  light_sum;

    iihc_pkg::out_item_t expected_outputs [$];
    int        mismatches   = 0;
    int        quiet_cycles = 0;
    int        polls_sent   = 0;
    bit        tx_idle_en   = 1'b1;
    bit        rx_idle_en   = 1'b1;
    int        rx_hold_left = 0;

    task automatic reset_controller_copy();
        levels.light_on_level  = iihc_pkg::LIGHT_ON_RESET;
        levels.mode_on_level   = iihc_pkg::MODE_ON_RESET;
        levels.mode_auto_level = iihc_pkg::MODE_AUTO_RESET;
        engine_on     = 1'b0;
        welcomed      = 1'b0;
        alarm_latched = 1'b0;
        report_done   = 1'b0;
        button_held   = 1'b0;
        buzzer_drive  = 1'b0;
        foreach (light_ring[i])
            light_ring[i] = '0;
        ring_pos  = 0;
        light_sum = 0;
    endtask

    function automatic logic auto_headlight(input logic [iihc_pkg::LEVEL_W-1:0] raw);
        logic [iihc_pkg::LEVEL_W-1:0] s;
        s = raw & iihc_pkg::SAMPLE_KEEP;
        light_sum = light_sum - light_ring[ring_pos] + s;
        light_ring[ring_pos] = s;
        ring_pos = (ring_pos + 1 >= iihc_pkg::AVG_DEPTH) ? 0 : ring_pos + 1;
        return light_sum <= levels.light_on_level * iihc_pkg::AVG_DEPTH;
    endfunction

    function automatic iihc_pkg::out_item_t predict_poll(input iihc_pkg::in_item_t p);
        iihc_pkg::out_item_t r;
        logic      rdy;
        logic      head;
        r = '0;
        if (p.driver_seat && !welcomed)
        begin
            welcomed      = 1'b1;
            r.msg_welcome = 1'b1;
        end
        rdy = p.driver_seat && p.passenger_seat && p.driver_belt && p.passenger_belt
              && !engine_on;
        if (!rdy && !engine_on && p.ignition_button && !alarm_latched)
        begin
            buzzer_drive  = 1'b1;
            alarm_latched = 1'b1;
        end
        if (p.ignition_button)
            button_held = 1'b1;
        else if (button_held)
        begin
            button_held = 1'b0;
            if (!engine_on && rdy)
            begin
                engine_on     = 1'b1;
                rdy           = 1'b0;
                r.msg_started = 1'b1;
                buzzer_drive  = 1'b0;
            end
            else if (engine_on)
            begin
                engine_on     = 1'b0;
                rdy           = 1'b0;
                r.msg_stopped = 1'b1;
            end
        end
        if (alarm_latched && p.ignition_button && !report_done)
        begin
            alarm_latched   = 1'b0;
            r.msg_inhibited = 1'b1;
            report_done     = 1'b1;
        end
        if (!engine_on)
            head = 1'b0;
        else if (p.mode_pot < levels.mode_on_level)
            head = 1'b0;
        else if (p.mode_pot < levels.mode_auto_level)
            head = 1'b1;
        else
            head = auto_headlight(p.light_sample);
        r.ignition_ready = rdy;
        r.engine_running = engine_on;
        r.headlight_on   = head;
        r.buzzer_on      = buzzer_drive;
        r.missing_mask   = {~p.passenger_belt, ~p.driver_belt, ~p.passenger_seat,
                            ~p.driver_seat};
        return r;
    endfunction

    task automatic check_field(input string name, input logic [3:0] exp_v,
                               input logic [3:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Predict on input accept, check on output accept, track levels
    always @(posedge clk)
    begin
        iihc_pkg::out_item_t exp_r;
        iihc_pkg::in_item_t  poll;
        bit        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg.valid && cfg.ready)
            begin
                moved = 1'b1;
                case (cfg.index)
                    iihc_pkg::CFG_LIGHT_ON:  levels.light_on_level  = cfg.data;
                    iihc_pkg::CFG_MODE_ON:   levels.mode_on_level   = cfg.data;
                    iihc_pkg::CFG_MODE_AUTO: levels.mode_auto_level = cfg.data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                moved = 1'b1;
                if (expected_outputs.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no expectation, expected none, actual %b", $time,
                             {out_ch.ignition_ready, out_ch.engine_running,
                              out_ch.headlight_on, out_ch.buzzer_on, out_ch.msg_welcome,
                              out_ch.msg_started, out_ch.msg_stopped, out_ch.msg_inhibited,
                              out_ch.missing_mask});
                end
                else
                begin
                    exp_r = expected_outputs.pop_front();
                    check_field("ignition_ready", exp_r.ignition_ready, out_ch.ignition_ready);
                    check_field("engine_running", exp_r.engine_running, out_ch.engine_running);
                    check_field("headlight_on", exp_r.headlight_on, out_ch.headlight_on);
                    check_field("buzzer_on", exp_r.buzzer_on, out_ch.buzzer_on);
                    check_field("msg_welcome", exp_r.msg_welcome, out_ch.msg_welcome);
                    check_field("msg_started", exp_r.msg_started, out_ch.msg_started);
                    check_field("msg_stopped", exp_r.msg_stopped, out_ch.msg_stopped);
                    check_field("msg_inhibited", exp_r.msg_inhibited, out_ch.msg_inhibited);
                    check_field("missing_mask", exp_r.missing_mask, out_ch.missing_mask);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                moved = 1'b1;
                poll.driver_seat     = in_ch.driver_seat;
                poll.passenger_seat  = in_ch.passenger_seat;
                poll.driver_belt     = in_ch.driver_belt;
                poll.passenger_belt  = in_ch.passenger_belt;
                poll.ignition_button = in_ch.ignition_button;
                poll.mode_pot        = in_ch.mode_pot;
                poll.light_sample    = in_ch.light_sample;
                expected_outputs.push_back(predict_poll(poll));
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    // Result receiver: random bursts of stall, long hold on request
    initial
    begin
        int burst_left;
        burst_left   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                out_ch.ready <= 1'b0;
            else if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_ch.ready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                burst_left   = $urandom_range(1, 6) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send_poll(input logic [3:0] occ, input logic btn,
                             input logic [iihc_pkg::LEVEL_W-1:0] pot,
                             input logic [iihc_pkg::LEVEL_W-1:0] light);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid           <= 1'b1;
        in_ch.driver_seat     <= occ[0];
        in_ch.passenger_seat  <= occ[1];
        in_ch.driver_belt     <= occ[2];
        in_ch.passenger_belt  <= occ[3];
        in_ch.ignition_button <= btn;
        in_ch.mode_pot        <= pot;
        in_ch.light_sample    <= light;
        do
            @(posedge clk);
        while (!in_ch.ready);
        polls_sent++;
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    task automatic write_level(input logic [iihc_pkg::CFG_IDX_W-1:0] idx,
                               input logic [iihc_pkg::LEVEL_W-1:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_levels(input logic [iihc_pkg::LEVEL_W-1:0] light_on,
                              input logic [iihc_pkg::LEVEL_W-1:0] mode_on,
                              input logic [iihc_pkg::LEVEL_W-1:0] mode_auto);
        wait_drain();
        write_level(iihc_pkg::CFG_LIGHT_ON, light_on);
        write_level(iihc_pkg::CFG_MODE_ON, mode_on);
        write_level(iihc_pkg::CFG_MODE_AUTO, mode_auto);
    endtask

    function automatic logic [iihc_pkg::LEVEL_W-1:0] rand_light();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return levels.light_on_level
                            + iihc_pkg::LEVEL_W'($urandom_range(0, 8)) - 16'd4;
            default: return iihc_pkg::LEVEL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [iihc_pkg::LEVEL_W-1:0] rand_pot();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return levels.mode_on_level - iihc_pkg::LEVEL_W'($urandom_range(0, 1));
            3:       return levels.mode_auto_level - iihc_pkg::LEVEL_W'($urandom_range(0, 1));
            default: return iihc_pkg::LEVEL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_noise(input int n);
        repeat (n)
            send_poll(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                      iihc_pkg::LEVEL_W'($urandom_range(0, 65535)),
                      iihc_pkg::LEVEL_W'($urandom_range(0, 65535)));
    endtask

    // One drive cycle: board, buckle, start, drive, stop
    task automatic run_session();
        int         n;
        logic [3:0] occ;
        if ($urandom_range(0, 3) == 0)
        begin
            occ = 4'($urandom_range(0, 14));
            send_poll(occ, 1'b1, rand_pot(), rand_light());
            send_poll(occ, 1'b0, rand_pot(), rand_light());
        end
        n = $urandom_range(0, 2);
        repeat (n)
            send_poll({3'($urandom_range(0, 7)), 1'b1}, 1'b0, rand_pot(), rand_light());
        n = $urandom_range(1, 3);
        repeat (n)
            send_poll(4'b1111, 1'b1, rand_pot(), rand_light());
        send_poll(4'b1111, 1'b0, rand_pot(), rand_light());
        n = $urandom_range(3, 30);
        repeat (n)
        begin
            occ = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'b1111;
            send_poll(occ, 1'($urandom_range(0, 15) == 0), rand_pot(), rand_light());
        end
        send_poll(4'($urandom_range(0, 15)), 1'b1, rand_pot(), rand_light());
        send_poll(4'($urandom_range(0, 15)), 1'b0, rand_pot(), rand_light());
    endtask

    task automatic run_traffic(input int n);
        int stop_at;
        stop_at = polls_sent + n;
        while (polls_sent < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
                send_noise($urandom_range(1, 8));
            else
                run_session();
        end
    endtask

    task automatic test_directed();
        send_poll(4'b0000, 1'b0, 16'h0000, 16'h0000);
        send_poll(4'b0001, 1'b0, 16'h0000, 16'h0000);
        send_poll(4'b0001, 1'b1, 16'hFFFF, 16'hFFFF);
        send_poll(4'b0001, 1'b0, 16'hFFFF, 16'hFFFF);
        send_poll(4'b1111, 1'b1, 16'h0000, 16'h0000);
        send_poll(4'b1111, 1'b0, 16'h0000, 16'h0000);
        send_poll(4'b1111, 1'b0, 16'h0000, 16'hFFFF);
        send_poll(4'b1111, 1'b0, 16'hFFFF, 16'h0000);
        repeat (7)
            send_poll(4'b1111, 1'b0, 16'hFFFF, 16'hFFFF);
        send_poll(4'b1111, 1'b0, iihc_pkg::MODE_ON_RESET - 16'd1, 16'hFFFF);
        send_poll(4'b1111, 1'b0, iihc_pkg::MODE_ON_RESET, 16'h0000);
        send_poll(4'b1111, 1'b0, iihc_pkg::MODE_AUTO_RESET - 16'd1, 16'h0000);
        send_poll(4'b0110, 1'b1, iihc_pkg::MODE_AUTO_RESET, 16'h1234);
        send_poll(4'b0110, 1'b0, iihc_pkg::MODE_AUTO_RESET, 16'h1234);
        send_poll(4'b1011, 1'b1, 16'h8000, 16'h8000);
        send_poll(4'b1011, 1'b0, 16'h8000, 16'h8000);
        send_poll(4'b1111, 1'b1, 16'h8000, 16'h8000);
        send_poll(4'b1111, 1'b0, 16'h8000, 16'h8000);
        send_poll(4'b1111, 1'b1, 16'h8000, 16'h8000);
        send_poll(4'b1111, 1'b0, 16'h8000, 16'h8000);
        wait_drain();
    endtask

    task automatic test_level_extremes();
        set_levels(16'h0000, 16'h0000, 16'h0000);
        run_traffic(100);
        set_levels(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_traffic(100);
        set_levels(16'h4000, 16'hC000, 16'h2000);
        run_traffic(100);
        set_levels(16'hFFFF, 16'h0000, 16'hFFFF);
        run_traffic(100);
        set_levels(iihc_pkg::LIGHT_ON_RESET, iihc_pkg::MODE_ON_RESET,
                   iihc_pkg::MODE_AUTO_RESET);
        run_traffic(60);
    endtask

    task automatic test_random_levels();
        logic [iihc_pkg::LEVEL_W-1:0] a;
        logic [iihc_pkg::LEVEL_W-1:0] b;
        repeat (8)
        begin
            a = iihc_pkg::LEVEL_W'($urandom_range(0, 65535));
            b = iihc_pkg::LEVEL_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 4) != 0 && a > b)
                {a, b} = {b, a};
            set_levels(iihc_pkg::LEVEL_W'($urandom_range(0, 65535)), a, b);
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            run_traffic(130);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_output_backpressure();
        wait_drain();
        rx_hold_left = LONG_HOLD;
        tx_idle_en   = 1'b0;
        run_traffic(60);
        tx_idle_en   = 1'b1;
        wait_drain();
    endtask

    task automatic test_sender_pause();
        run_traffic(20);
        wait_drain();
        run_traffic(20);
    endtask

    task automatic test_full_rate();
        set_levels(iihc_pkg::LIGHT_ON_RESET, iihc_pkg::MODE_ON_RESET,
                   iihc_pkg::MODE_AUTO_RESET);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_traffic(150);
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.driver_seat     = 1'b0;
        in_ch.passenger_seat  = 1'b0;
        in_ch.driver_belt     = 1'b0;
        in_ch.passenger_belt  = 1'b0;
        in_ch.ignition_button = 1'b0;
        in_ch.mode_pot        = '0;
        in_ch.light_sample    = '0;
        cfg.valid             = 1'b0;
        cfg.index             = iihc_pkg::CFG_LIGHT_ON;
        cfg.data              = '0;
        reset_controller_copy();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_level_extremes();
        test_random_levels();
        test_output_backpressure();
        test_sender_pause();
        test_full_rate();

        wait_drain();
        if (mismatches == 0 && expected_outputs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[ignition_interlock_headlight_ctrl_top.f]
design/iihc_pkg.sv
design/iihc_ifs.sv
design/iihc_cfg_regs.sv
design/iihc_light_avg.sv
design/iihc_ctrl.sv
design/ignition_interlock_headlight_ctrl_top.sv
tb/sv/tb_ignition_interlock_headlight_ctrl_top.sv
